// ----- sv/sgm_pkg.sv -----
package sgm_pkg;

    localparam int MaxWidth = 2048;
    localparam int ColW     = $clog2(MaxWidth);
    localparam int RowW     = 13;  // row runs to height + 1 while flushing
    localparam int PixW     = 24;

    localparam logic [11:0] WidthReset  = 12'd640;
    localparam logic [11:0] HeightReset = 12'd480;

    // configuration register indexes
    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    typedef logic [PixW-1:0] pix_t;

    // job handed from the front (window) to the back (math)
    typedef struct packed {
        pix_t [2:0][2:0] win;  // [row][col]
        logic            last;
    } job_t;

    // front-end state machine
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_READ,
        FR_WORK
    } fr_state_t;

    // back-end state machine
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_DONE
    } bk_state_t;

endpackage

// ----- sv/sgm_front.sv -----
module sgm_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_idx,
    input  logic                 cfg_hit,
    input  logic [11:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_blue_in,
    input  logic [7:0]           s_green_in,
    input  logic [7:0]           s_red_in,
    input  logic                 s_pad_item,
    output logic                 job_valid,
    output sgm_pkg::job_t        job,
    input  logic                 q_free
);
    import sgm_pkg::*;

    logic [11:0] width_reg, height_reg;
    logic [RowW-1:0] w_eff, h_eff;
    logic [RowW-1:0] col_reg, row_reg;
    pix_t [2:0][2:0] win_reg;
    pix_t upper_mem [MaxWidth];
    pix_t middle_mem [MaxWidth];
    pix_t top_rd_reg, mid_rd_reg, px_reg;
    fr_state_t state_reg, state_next;
    logic [1:0] njob_reg;  // jobs still to push for this item
    logic in_mem;
    logic flush_now;
    logic accept;
    logic [RowW-1:0] cr2, cr1;
    job_t edge_job, mid_job;
    logic edge_need, mid_need, edge_last;
    pix_t [2:0][2:0] win_shift;

    // clamp registers to usable range
    always_comb begin
        w_eff = RowW'(width_reg);
        if (width_reg < 12'd2) w_eff = RowW'(2);
        else if (width_reg > 12'(MaxWidth)) w_eff = RowW'(MaxWidth);
        h_eff = (height_reg < 12'd2) ? RowW'(2) : RowW'(height_reg);
    end

    assign flush_now = (row_reg >= h_eff);
    assign s_ready   = (state_reg == FR_IDLE) && !cfg_wr_en;
    assign accept    = s_valid && s_ready && (flush_now || !s_pad_item);
    assign in_mem    = (col_reg < RowW'(MaxWidth));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: if (accept) state_next = FR_READ;
            FR_READ: state_next = FR_WORK;
            FR_WORK: if (njob_reg == 2'd0) state_next = FR_IDLE;
            default: state_next = FR_IDLE;
        endcase
    end

    assign cr2 = row_reg - RowW'(2);
    assign cr1 = row_reg - RowW'(1);
    assign edge_need = (col_reg == '0) && (row_reg >= RowW'(2));
    assign edge_last = (cr2 == h_eff - RowW'(1));
    assign mid_need  = (col_reg >= RowW'(1)) && (row_reg >= RowW'(1));

    // right-edge window from the unshifted window
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            edge_job.win[a][0] = win_reg[a][1];
            edge_job.win[a][1] = win_reg[a][2];
            edge_job.win[a][2] = win_reg[a][1];
        end
        if (cr2 == '0)
            for (int b = 0; b < 3; b++) edge_job.win[0][b] = edge_job.win[2][b];
        if (edge_last)
            for (int b = 0; b < 3; b++) edge_job.win[2][b] = edge_job.win[0][b];
        edge_job.last = edge_last;
    end

    // shifted window with new column
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            win_shift[a][0] = win_reg[a][1];
            win_shift[a][1] = win_reg[a][2];
        end
        win_shift[0][2] = in_mem ? top_rd_reg : '0;
        win_shift[1][2] = in_mem ? mid_rd_reg : '0;
        win_shift[2][2] = px_reg;
        mid_job.win = win_shift;
        if (col_reg == RowW'(1))
            for (int a = 0; a < 3; a++) mid_job.win[a][0] = win_shift[a][2];
        if (cr1 == '0)
            for (int b = 0; b < 3; b++) mid_job.win[0][b] = mid_job.win[2][b];
        if (cr1 == h_eff - RowW'(1))
            for (int b = 0; b < 3; b++) mid_job.win[2][b] = mid_job.win[0][b];
        mid_job.last = 1'b0;
    end

    // job output: edge job first, then the regular one
    always_comb begin
        job_valid = 1'b0;
        job       = mid_job;
        if (state_reg == FR_WORK) begin
            if (njob_reg == 2'd2) begin
                job_valid = edge_need;
                job       = edge_job;
            end else if (njob_reg == 2'd1) begin
                job_valid = mid_need;
            end
        end
    end

    // line stores
    always_ff @(posedge aclk) begin
        if (state_reg == FR_IDLE && accept) begin
            top_rd_reg <= upper_mem[col_reg[ColW-1:0]];
            mid_rd_reg <= middle_mem[col_reg[ColW-1:0]];
        end
        if (state_reg == FR_READ && in_mem && !(edge_need && edge_last)) begin
            upper_mem[col_reg[ColW-1:0]]  <= mid_rd_reg;
            middle_mem[col_reg[ColW-1:0]] <= px_reg;
        end
    end

    // control and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FR_IDLE;
            width_reg  <= WidthReset;
            height_reg <= HeightReset;
            col_reg    <= '0;
            row_reg    <= '0;
            njob_reg   <= '0;
            win_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_hit) begin
                if (cfg_idx == RegWidth) width_reg <= cfg_data;
                if (cfg_idx == RegHeight) height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
            end
            if (state_reg == FR_IDLE && accept) begin
                px_reg <= flush_now ? '0 : {s_red_in, s_green_in, s_blue_in};
            end
            if (state_reg == FR_READ) njob_reg <= 2'd2;
            if (state_reg == FR_WORK) begin
                if (njob_reg == 2'd2) begin
                    if (!edge_need || q_free) begin
                        if (edge_need && edge_last) begin
                            col_reg  <= '0;
                            row_reg  <= '0;
                            njob_reg <= 2'd0;
                        end else begin
                            njob_reg <= 2'd1;
                        end
                    end
                end else if (njob_reg == 2'd1) begin
                    if (!mid_need || q_free) begin
                        win_reg  <= win_shift;
                        njob_reg <= 2'd0;
                        if (col_reg + RowW'(1) >= w_eff) begin
                            col_reg <= '0;
                            row_reg <= row_reg + RowW'(1);
                        end else begin
                            col_reg <= col_reg + RowW'(1);
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- sv/sgm_queue.sv -----
module sgm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  sgm_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output sgm_pkg::job_t rd_data
);
    import sgm_pkg::*;

    job_t mem_reg [2];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // two-entry fifo
    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= wp_reg + 1'b1;
            if (do_rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

// ----- sv/sgm_back.sv -----
module sgm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  sgm_pkg::job_t job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_blue_mag,
    output logic [7:0]    m_green_mag,
    output logic [7:0]    m_red_mag,
    output logic          m_frame_end
);
    import sgm_pkg::*;

    bk_state_t state_reg, state_next;
    logic [16:0] sq_reg [3];
    logic [7:0]  root_reg [3];
    logic [2:0]  bit_reg;
    logic        last_reg;
    logic        sat_reg [3];
    logic [17:0] sq_next [3];

    // gradient squares per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic signed [21:0] gx, gy;
            logic signed [21:0] v [3][3];
            logic [21:0] s;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    v[a][b] = 22'(job.win[a][b][8*ch +: 8]);
            gx = (v[0][2] + 22'sd2 * v[1][2] + v[2][2])
               - (v[0][0] + 22'sd2 * v[1][0] + v[2][0]);
            gy = (v[2][0] + 22'sd2 * v[2][1] + v[2][2])
               - (v[0][0] + 22'sd2 * v[0][1] + v[0][2]);
            s = $unsigned(gx * gx) + $unsigned(gy * gy);
            sq_next[ch] = (s >= 22'd65536) ? 18'h3ffff : 18'(s);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (job_valid) state_next = BK_ROOT;
            BK_ROOT: if (bit_reg == 3'd0) state_next = BK_DONE;
            BK_DONE: if (m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        job_ready   = (state_reg == BK_IDLE);
        m_valid     = (state_reg == BK_DONE);
        m_blue_mag  = root_reg[0];
        m_green_mag = root_reg[1];
        m_red_mag   = root_reg[2];
        m_frame_end = last_reg;
    end

    // bit-serial square root, one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == BK_IDLE && job_valid) begin
            for (int ch = 0; ch < 3; ch++) begin
                sat_reg[ch]  <= sq_next[ch][17];
                sq_reg[ch]   <= sq_next[ch][16:0];
                root_reg[ch] <= '0;
            end
            bit_reg  <= 3'd7;
            last_reg <= job.last;
        end else if (state_reg == BK_ROOT) begin
            for (int ch = 0; ch < 3; ch++) begin
                logic [7:0] t;
                t = root_reg[ch] | (8'd1 << bit_reg);
                if (sat_reg[ch]) root_reg[ch] <= 8'hff;
                else if ({1'b0, 16'(t) * 16'(t)} <= sq_reg[ch]) root_reg[ch] <= t;
            end
            bit_reg <= bit_reg - 3'd1;
        end
    end

endmodule

// ----- sv/sobel_gradient_magnitude_rgb_core.sv -----
// Sobel gradient magnitude, RGB, 3x3 window with reflect-101 borders.
// Front end: each accepted pixel or flush word steps through accept, line store
// read, edge job, regular job and back to idle; the word that ends a frame skips
// the regular job, a job waits while the queue is full, and a pad word inside a
// frame is dropped. Back end: load, 8 bit-serial root steps, output hold.
// Results lag the input by one line plus one pixel; pad words flush the frame.
// Reset (aresetn low, synchronous) clears counters, window, queue and registers
// to 640x480; line stores are not cleared.
module sobel_gradient_magnitude_rgb_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_blue_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_red_in,
    input  logic        s_pad_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_blue_mag,
    output logic [7:0]  m_green_mag,
    output logic [7:0]  m_red_mag,
    output logic        m_frame_end
);
    import sgm_pkg::*;

    logic jv, jr, qv, qr;
    job_t jd, qd;

    sgm_front u_front (
        .aclk, .aresetn, .cfg_wr_en,
        .cfg_idx(cfg_index[0:0]), .cfg_hit(cfg_index[1] == 1'b0), .cfg_data,
        .s_valid, .s_ready, .s_blue_in, .s_green_in, .s_red_in, .s_pad_item,
        .job_valid(jv), .job(jd), .q_free(jr)
    );

    sgm_queue u_queue (
        .aclk, .aresetn, .wr_valid(jv), .wr_ready(jr), .wr_data(jd),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qd)
    );

    sgm_back u_back (
        .aclk, .aresetn, .job_valid(qv), .job_ready(qr), .job(qd),
        .m_valid, .m_ready, .m_blue_mag, .m_green_mag, .m_red_mag, .m_frame_end
    );

    // output word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blue_mag))
        else $error("result word changed while stalled");
    // front end holds its pending job while the queue is full
    a_q: assert property (@(posedge aclk) disable iff (!aresetn)
        jv && !jr |=> $stable(u_front.njob_reg) || !aresetn)
        else $error("job lost at queue");

endmodule
